// ===== hdl/ssc_pkg.sv =====
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int IN_FIELD_W      = 11;
    localparam int MODE_W          = 5;
    localparam int SCALE_W         = 24;
    localparam int SCALE_FRAC_BITS = 16;
    localparam int INT_W           = 16;
    localparam int OUT_W           = 13;
    localparam int Q_W             = 11;
    localparam int P_W             = 13;
    localparam int NUM_W           = P_W + SCALE_FRAC_BITS;
    localparam int DEN_W           = SCALE_W + Q_W;
    localparam int SAT_SH          = SCALE_FRAC_BITS - Q_W;
    localparam int DIV_LANES       = 3;
    localparam int CFG_ADDR_W      = 1;

    localparam int LANE_SX  = 0;
    localparam int LANE_SY  = 1;
    localparam int LANE_SY2 = 2;

    localparam int MODE_SPLIT   = 0;
    localparam int MODE_PRECISE = 1;
    localparam int MODE_HFLIP   = 2;
    localparam int MODE_VFLIP   = 3;
    localparam int MODE_SCALED  = 4;

    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC_BITS;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CANVAS_X = 1'b0,
        CFG_CANVAS_Y = 1'b1
    } cfg_idx_t;

    typedef logic signed [INT_W-1:0] coord_t;
    typedef logic [IN_FIELD_W-1:0]   dim_t;
    typedef logic signed [OUT_W-1:0] ocoord_t;

    // packed so that dest_x sits in the lowest bits
    typedef struct packed {
        logic [SCALE_W-1:0]    scale;
        logic [MODE_W-1:0]     mode_bits;
        dim_t                  clip_bottom;
        dim_t                  clip_top;
        dim_t                  clip_right;
        dim_t                  clip_left;
        dim_t                  src_h;
        dim_t                  src_w;
        dim_t                  dest_h;
        dim_t                  dest_w;
        logic [IN_FIELD_W-1:0] dest_y;
        logic [IN_FIELD_W-1:0] dest_x;
    } in_beat_t;

    localparam int IN_BEAT_W = $bits(in_beat_t);
    localparam int S_TDATA_W = ((IN_BEAT_W + 7) / 8) * 8;

    // packed so that out_x sits in the lowest bits
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        ocoord_t           sy;
        ocoord_t           sx;
        ocoord_t           h;
        ocoord_t           w;
        ocoord_t           y;
        ocoord_t           x;
    } cmd_t;

    localparam int CMD_W     = $bits(cmd_t);
    localparam int M_TDATA_W = ((CMD_W + 7) / 8) * 8;

    typedef struct packed {
        coord_t            x;
        coord_t            y;
        coord_t            w;
        coord_t            hh;
        coord_t            ylo;
        coord_t            hlo;
        logic              split;
        logic [MODE_W-1:0] mode;
        dim_t              sw;
        dim_t              sh;
        logic              mirror;
        logic              scaled;
        coord_t            sx;
        coord_t            sy;
        coord_t            sy2;
    } side_t;

    typedef struct packed {
        logic [P_W-1:0] p;
        logic           pos;
        logic           sat;
    } lane_in_t;

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           pos;
        logic           sat;
    } lane_out_t;

    function automatic coord_t sext_f(input logic [IN_FIELD_W-1:0] v);
        return coord_t'($signed(v));
    endfunction

    function automatic coord_t zext_f(input dim_t v);
        return coord_t'({1'b0, v});
    endfunction

endpackage

// ===== hdl/ssc_front.sv =====
`timescale 1ns / 1ps

module ssc_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  cfg_we,
    input  logic [ssc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [ssc_pkg::IN_FIELD_W-1:0]        cfg_wdata,
    input  logic                                  in_valid,
    input  logic [ssc_pkg::S_TDATA_W-1:0]         in_data,
    output logic                                  out_valid,
    output ssc_pkg::side_t                        out_side,
    output ssc_pkg::lane_in_t [ssc_pkg::DIV_LANES-1:0] out_lane,
    output logic [ssc_pkg::SCALE_W-1:0]           out_scale
);
    import ssc_pkg::*;

    typedef struct packed {
        coord_t             x;
        coord_t             y;
        coord_t             w;
        coord_t             h;
        dim_t               sw;
        dim_t               sh;
        dim_t               cl;
        dim_t               ct;
        dim_t               cb;
        logic [MODE_W-1:0]  mode;
        logic [SCALE_W-1:0] scale;
    } stage_a_t;

    logic [IN_FIELD_W-1:0] canvas_x_reg;
    logic [IN_FIELD_W-1:0] canvas_y_reg;

    in_beat_t           beat;
    logic               a_valid_reg;
    stage_a_t           a_reg;
    stage_a_t           a_next;
    logic               b_valid_reg;
    side_t              b_reg;
    side_t              b_next;
    logic [SCALE_W-1:0] b_scale_reg;
    logic               c_valid_reg;
    side_t              c_reg;
    logic [SCALE_W-1:0] c_scale_reg;
    lane_in_t [DIV_LANES-1:0] c_lane_reg;
    lane_in_t [DIV_LANES-1:0] c_lane_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_x_reg <= '0;
            canvas_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_CANVAS_X: canvas_x_reg <= cfg_wdata;
                CFG_CANVAS_Y: canvas_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // offset and shrink by origin and margins
    always_comb
    begin
        beat         = in_beat_t'(in_data[IN_BEAT_W-1:0]);
        a_next.x     = sext_f(beat.dest_x) + sext_f(canvas_x_reg) + zext_f(beat.clip_left);
        a_next.y     = sext_f(beat.dest_y) + sext_f(canvas_y_reg) + zext_f(beat.clip_top);
        a_next.w     = zext_f(beat.dest_w) - (zext_f(beat.clip_right) + zext_f(beat.clip_left));
        a_next.h     = zext_f(beat.dest_h) - (zext_f(beat.clip_bottom) + zext_f(beat.clip_top));
        a_next.sw    = beat.src_w;
        a_next.sh    = beat.src_h;
        a_next.cl    = beat.clip_left;
        a_next.ct    = beat.clip_top;
        a_next.cb    = beat.clip_bottom;
        a_next.mode  = beat.mode_bits;
        a_next.scale = beat.scale;
    end

    // band split, even snap, flip source starts
    always_comb
    begin
        b_next.hh = a_reg.mode[MODE_SPLIT] ? (a_reg.h >>> 1) : a_reg.h;
        b_next.mode = a_reg.mode;
        if (a_reg.mode[MODE_PRECISE])
        begin
            b_next.x = a_reg.x;
            b_next.w = a_reg.w;
            if (!a_reg.x[0] && !a_reg.w[0] && !a_reg.mode[MODE_SCALED])
                b_next.mode[MODE_PRECISE] = 1'b0;
        end
        else
        begin
            b_next.x = {a_reg.x[INT_W-1:1], 1'b0};
            b_next.w = {a_reg.w[INT_W-1:1], 1'b0};
        end
        b_next.y      = a_reg.y;
        b_next.ylo    = a_reg.y + b_next.hh;
        b_next.hlo    = a_reg.h - b_next.hh;
        b_next.split  = a_reg.mode[MODE_SPLIT] && (a_reg.h > coord_t'(0));
        b_next.sw     = a_reg.sw;
        b_next.sh     = a_reg.sh;
        b_next.mirror = a_reg.mode[MODE_HFLIP] ^ a_reg.mode[MODE_VFLIP];
        b_next.scaled = a_reg.mode[MODE_SCALED];
        b_next.sx     = b_next.mirror ? (b_next.w + zext_f(a_reg.cl)) : zext_f(a_reg.cl);
        if (a_reg.mode[MODE_VFLIP])
        begin
            b_next.sy  = zext_f(a_reg.cb) + b_next.hlo;
            b_next.sy2 = zext_f(a_reg.cb);
        end
        else
        begin
            b_next.sy  = zext_f(a_reg.ct);
            b_next.sy2 = zext_f(a_reg.ct) + b_next.hh;
        end
    end

    // divider operands: nudged start, sign and overflow check
    always_comb
    begin
        coord_t                                 nudge;
        coord_t                                 t;
        coord_t                                 s [DIV_LANES];
        logic [P_W+SAT_SH-1:0]                  pw;
        nudge          = (b_scale_reg > SCALE_ONE) ? coord_t'(1) : coord_t'(0);
        s[LANE_SX]     = b_reg.sx;
        s[LANE_SY]     = b_reg.sy;
        s[LANE_SY2]    = b_reg.sy2;
        for (int l = 0; l < DIV_LANES; l++)
        begin
            t                  = s[l] + nudge;
            c_lane_next[l].pos = (t > coord_t'(0));
            c_lane_next[l].p   = t[P_W-1:0];
            pw                 = {t[P_W-1:0], {SAT_SH{1'b0}}};
            c_lane_next[l].sat = (SCALE_W'(pw) >= b_scale_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg       <= a_next;
            b_reg       <= b_next;
            b_scale_reg <= a_reg.scale;
            c_reg       <= b_reg;
            c_scale_reg <= b_scale_reg;
            c_lane_reg  <= c_lane_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_side  = c_reg;
    assign out_lane  = c_lane_reg;
    assign out_scale = c_scale_reg;

endmodule

// ===== hdl/ssc_div.sv =====
`timescale 1ns / 1ps

module ssc_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  ssc_pkg::side_t                         in_side,
    input  ssc_pkg::lane_in_t [ssc_pkg::DIV_LANES-1:0]  in_lane,
    input  logic [ssc_pkg::SCALE_W-1:0]            in_scale,
    output logic                                   out_valid,
    output ssc_pkg::side_t                         out_side,
    output ssc_pkg::lane_out_t [ssc_pkg::DIV_LANES-1:0] out_lane
);
    import ssc_pkg::*;

    // one quotient bit per stage, msb first
    logic [Q_W-1:0]       v_reg;
    side_t                side_reg  [Q_W];
    logic [SCALE_W-1:0]   scale_reg [Q_W];
    logic [NUM_W-1:0]     rem_reg   [Q_W][DIV_LANES];
    logic [Q_W-1:0]       q_reg     [Q_W][DIV_LANES];
    logic [DIV_LANES-1:0] pos_reg   [Q_W];
    logic [DIV_LANES-1:0] sat_reg   [Q_W];

    for (genvar j = 0; j < Q_W; j++)
    begin : g_step
        localparam int BIT = Q_W - 1 - j;

        logic                 v_in;
        side_t                side_in;
        logic [SCALE_W-1:0]   scale_in;
        logic [NUM_W-1:0]     rem_in  [DIV_LANES];
        logic [Q_W-1:0]       q_in    [DIV_LANES];
        logic [DIV_LANES-1:0] pos_in;
        logic [DIV_LANES-1:0] sat_in;
        logic [NUM_W-1:0]     rem_next [DIV_LANES];
        logic [Q_W-1:0]       q_next   [DIV_LANES];

        if (j == 0)
        begin : g_first
            always_comb
            begin
                v_in     = in_valid;
                side_in  = in_side;
                scale_in = in_scale;
                for (int l = 0; l < DIV_LANES; l++)
                begin
                    rem_in[l] = {in_lane[l].p, {SCALE_FRAC_BITS{1'b0}}};
                    q_in[l]   = '0;
                    pos_in[l] = in_lane[l].pos;
                    sat_in[l] = in_lane[l].sat;
                end
            end
        end
        else
        begin : g_chain
            always_comb
            begin
                v_in     = v_reg[j-1];
                side_in  = side_reg[j-1];
                scale_in = scale_reg[j-1];
                for (int l = 0; l < DIV_LANES; l++)
                begin
                    rem_in[l] = rem_reg[j-1][l];
                    q_in[l]   = q_reg[j-1][l];
                end
                pos_in = pos_reg[j-1];
                sat_in = sat_reg[j-1];
            end
        end

        always_comb
        begin
            logic [DEN_W-1:0] d;
            logic [DEN_W-1:0] r;
            d = DEN_W'(scale_in) << BIT;
            for (int l = 0; l < DIV_LANES; l++)
            begin
                r = DEN_W'(rem_in[l]);
                if (r >= d)
                begin
                    rem_next[l] = NUM_W'(r - d);
                    q_next[l]   = q_in[l] | (Q_W'(1) << BIT);
                end
                else
                begin
                    rem_next[l] = rem_in[l];
                    q_next[l]   = q_in[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j]  <= side_in;
                scale_reg[j] <= scale_in;
                pos_reg[j]   <= pos_in;
                sat_reg[j]   <= sat_in;
                for (int l = 0; l < DIV_LANES; l++)
                begin
                    rem_reg[j][l] <= rem_next[l];
                    q_reg[j][l]   <= q_next[l];
                end
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

    for (genvar l = 0; l < DIV_LANES; l++)
    begin : g_out
        assign out_lane[l].q   = q_reg[Q_W-1][l];
        assign out_lane[l].pos = pos_reg[Q_W-1][l];
        assign out_lane[l].sat = sat_reg[Q_W-1][l];
    end

endmodule

// ===== hdl/ssc_back.sv =====
`timescale 1ns / 1ps

module ssc_back #(
    parameter int COORD_WIDTH = 13
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  ssc_pkg::side_t                         in_side,
    input  ssc_pkg::lane_out_t [ssc_pkg::DIV_LANES-1:0] in_lane,
    output logic                                   en,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [ssc_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                   m_tuser,
    output logic                                   m_tlast
);
    import ssc_pkg::*;

    localparam int WRAP_SH = INT_W - COORD_WIDTH;

    function automatic coord_t lane_val(input lane_out_t l, input coord_t raw,
                                        input dim_t lim, input logic scaled);
        coord_t r;
        if (!scaled)
            r = raw;
        else if (!l.pos)
            r = '0;
        else if (l.sat || (dim_t'(l.q) > lim))
            r = zext_f(lim);
        else
            r = zext_f(dim_t'(l.q));
        return r;
    endfunction

    function automatic ocoord_t wrap_f(input coord_t v);
        coord_t t;
        t = v <<< WRAP_SH;
        t = t >>> WRAP_SH;
        return t[OUT_W-1:0];
    endfunction

    logic   hold_valid_reg;
    logic   second_reg;
    cmd_t   lo_reg;
    cmd_t   hi_reg;
    cmd_t   lo_next;
    cmd_t   hi_next;
    cmd_t   cur;
    logic   take;

    // clamp, mirror and build both band commands
    always_comb
    begin
        coord_t sx;
        coord_t sy;
        coord_t sy2;
        sx  = lane_val(in_lane[LANE_SX], in_side.sx, in_side.sw, in_side.scaled);
        sy  = lane_val(in_lane[LANE_SY], in_side.sy, in_side.sh, in_side.scaled);
        sy2 = lane_val(in_lane[LANE_SY2], in_side.sy2, in_side.sh, in_side.scaled);
        if (in_side.mirror)
            sx = zext_f(in_side.sw) - sx;

        hi_next.x    = wrap_f(in_side.x);
        hi_next.y    = wrap_f(in_side.y);
        hi_next.w    = wrap_f(in_side.w);
        hi_next.h    = wrap_f(in_side.hh);
        hi_next.sx   = wrap_f(sx);
        hi_next.sy   = wrap_f(sy);
        hi_next.mode = in_side.mode;

        lo_next      = hi_next;
        lo_next.y    = wrap_f(in_side.ylo);
        lo_next.h    = wrap_f(in_side.hlo);
        lo_next.sy   = wrap_f(sy2);
    end

    assign take = !hold_valid_reg || (m_tready && !second_reg);
    assign en   = take || !in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            second_reg     <= 1'b0;
        end
        else if (take)
        begin
            hold_valid_reg <= in_valid;
            second_reg     <= in_valid && in_side.split;
        end
        else if (m_tready)
        begin
            second_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign cur      = second_reg ? lo_reg : hi_reg;
    assign m_tvalid = hold_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-CMD_W){1'b0}}, cur};
    assign m_tuser  = second_reg;
    assign m_tlast  = !second_reg;

endmodule

// ===== hdl/sprite_clip_source_setup.sv =====
`timescale 1ns / 1ps
// sprite clip and source setup for the blitter
// input stream: one beat per sprite; s_tdata carries the destination rectangle,
//   source size, four clip margins, mode bits and an 8.16 scale
// output stream: one command per beat; a split sprite with a positive clipped
//   height gives two beats, the lower band first (tuser high), then the upper
//   band (tlast high); any other sprite gives one beat with tlast high
// config port: cfg_we writes cfg_wdata into the canvas origin selected by
//   cfg_addr (0 horizontal, 1 vertical); write only while the block is idle
// path: a sprite beat that is taken passes three setup stages, eleven divider
//   stages and one output register before its first command leaves
// throughput: one sprite per cycle while m_tready is high; a split sprite holds
//   the output register for both its commands, the output port carrying one command a cycle
// the source divide runs as a pipeline with one quotient bit per stage
// reset: canvas origin goes to zero and the pipeline empties
// stall: with m_tready low the finished command waits in the output register
//   and the pipeline keeps moving into its empty stages; s_tready drops only
//   when a sprite is waiting at the end of the pipeline behind that register
module sprite_clip_source_setup #(
    parameter int COORD_WIDTH = 13
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ssc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [ssc_pkg::IN_FIELD_W-1:0]        cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // dest_x, dest_y, dest_w, dest_h, src_w, src_h, clip_left, clip_right,
    // clip_top, clip_bottom, mode_bits, scale
    input  logic [ssc_pkg::S_TDATA_W-1:0]         s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // out_x, out_y, out_w, out_h, src_start_x, src_start_y, out_mode
    output logic [ssc_pkg::M_TDATA_W-1:0]         m_tdata,
    // for_second_core
    output logic                                  m_tuser,
    output logic                                  m_tlast
);
    import ssc_pkg::*;

    logic                     en;
    logic                     fr_valid;
    side_t                    fr_side;
    lane_in_t [DIV_LANES-1:0] fr_lane;
    logic [SCALE_W-1:0]       fr_scale;
    logic                      dv_valid;
    side_t                     dv_side;
    lane_out_t [DIV_LANES-1:0] dv_lane;

    ssc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .out_lane  (fr_lane),
        .out_scale (fr_scale)
    );

    ssc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_lane   (fr_lane),
        .in_scale  (fr_scale),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_lane  (dv_lane)
    );

    ssc_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dv_valid),
        .in_side  (dv_side),
        .in_lane  (dv_lane),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign s_tready = en;

    // lower band beat is always followed by the upper band of the same sprite
    a_band_order : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tuser) |=> (m_tvalid && m_tlast && !m_tuser))
        else $error("lower band not followed by upper band");

    // both bands of a sprite share the clipped width
    a_band_width : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tuser) |=> (m_tdata[38:26] == $past(m_tdata[38:26])))
        else $error("band widths differ");

    // input only backs up behind a held command
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output register");

endmodule
